/* hdl/lzss_pkg.sv */
package lzss_pkg;

    // The header carries a 24-bit output size.
    localparam int HDR_W = 24;

    // Parse phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_FLAG   = 3'd2;
    localparam logic [2:0] PH_TOKEN  = 3'd3;
    localparam logic [2:0] PH_REF_LO = 3'd4;

    // Where the byte held in the output stage comes from.
    localparam logic [1:0] SRC_MEM  = 2'd0;
    localparam logic [1:0] SRC_LAST = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LIT  = 2'd3;

    localparam logic [4:0] MIN_MATCH  = 5'd3;
    localparam logic [3:0] FLAG_COUNT = 4'd8;

endpackage

/* hdl/lzss_stream_decompressor.sv */
// A literal appears at the output in the cycle after its transaction; the first byte of
// a back-reference goes through the copy engine and then the output stage register.
// Header, flag and literal bytes are taken one per cycle while the output stage is free; a
// back-reference holds the input while it is copied, one byte per cycle as output allows.
// Reset clears all control state at once; the history window is not cleared.
module lzss_stream_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int SIZE_BITS    = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_first_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_end
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [lzss_pkg::HDR_W-1:0] SIZE_MAX =
        {lzss_pkg::HDR_W{1'b1}} >> (lzss_pkg::HDR_W - SIZE_BITS);
    localparam logic [CNT_W-1:0] PROD_MAX = CNT_W'(WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] DISP_ONE = CNT_W'(1);

    // Parser state
    logic [2:0]                   r_phase,  n_phase;
    logic [1:0]                   r_hcnt,   n_hcnt;
    logic [lzss_pkg::HDR_W-1:0]   r_rem,    n_rem;
    logic [7:0]                   r_flags,  n_flags;
    logic [3:0]                   r_fused,  n_fused;
    logic [7:0]                   r_tok_hi, n_tok_hi;

    // Copy engine and pointers
    logic [PTR_W-1:0] r_iptr;
    logic [CNT_W-1:0] r_prod;
    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [CNT_W-1:0] r_disp;
    logic             r_ref_end;

    // Output stage
    logic             r_s2_vld;
    logic [1:0]       r_s2_src;
    logic [7:0]       r_s2_lit;
    logic [PTR_W-1:0] r_s2_addr;
    logic             r_s2_last;
    logic             r_s2_end;
    logic [7:0]       r_last_byte;
    logic [7:0]       r_mem_q;

    logic [7:0] mem [WINDOW_DEPTH];

    logic                       s2_free;
    logic                       in_acc;
    logic                       pop;
    logic                       cp_issue;
    logic                       cp_zero;
    logic [1:0]                 cp_src;
    logic [PTR_W-1:0]           rd_addr;
    logic                       issue;
    logic                       lit_push;
    logic                       lit_end;
    logic                       ref_start;
    logic [4:0]                 ref_len;
    logic                       ref_end;
    logic [CNT_W-1:0]           ref_disp;
    logic                       first_acc;
    logic [lzss_pkg::HDR_W-1:0] hdr_acc;
    logic [lzss_pkg::HDR_W-1:0] rem_dec;
    logic [lzss_pkg::HDR_W-1:0] rem_ref;
    logic [4:0]                 tok_len;
    logic [3:0]                 fused_inc;

    assign s2_free    = !r_s2_vld || i_out_ready;
    assign o_in_ready = !r_busy && s2_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign pop        = r_s2_vld && i_out_ready;
    assign first_acc  = in_acc && i_first_of_stream;

    // Copy issue: one byte per cycle while the output stage can take it.
    assign cp_issue = r_busy && s2_free;
    assign cp_zero  = r_disp > r_prod;
    assign cp_src   = cp_zero ? lzss_pkg::SRC_ZERO :
                      (r_disp == DISP_ONE) ? lzss_pkg::SRC_LAST : lzss_pkg::SRC_MEM;
    assign rd_addr  = r_iptr - r_disp[PTR_W-1:0];

    assign rem_dec   = r_rem - 1'b1;
    assign tok_len   = {1'b0, r_tok_hi[7:4]} + lzss_pkg::MIN_MATCH;
    assign ref_len   = (r_rem < {{(lzss_pkg::HDR_W-5){1'b0}}, tok_len}) ? r_rem[4:0] : tok_len;
    assign rem_ref   = r_rem - {{(lzss_pkg::HDR_W-5){1'b0}}, ref_len};
    assign ref_disp  = CNT_W'({r_tok_hi[3:0], i_in_byte}) + DISP_ONE;
    assign fused_inc = r_fused + 1'b1;

    always_comb begin
        case (r_hcnt)
            2'd1:    hdr_acc = r_rem | {16'b0, i_in_byte};
            2'd2:    hdr_acc = r_rem | {8'b0, i_in_byte, 8'b0};
            default: hdr_acc = r_rem | {i_in_byte, 16'b0};
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_rem     = r_rem;
        n_flags   = r_flags;
        n_fused   = r_fused;
        n_tok_hi  = r_tok_hi;
        lit_push  = 1'b0;
        lit_end   = 1'b0;
        ref_start = 1'b0;
        ref_end   = 1'b0;
        if (in_acc) begin
            if (i_first_of_stream) begin
                n_phase  = lzss_pkg::PH_HEADER;
                n_hcnt   = 2'd1;
                n_rem    = '0;
                n_flags  = '0;
                n_fused  = '0;
                n_tok_hi = '0;
            end else begin
                case (r_phase)
                    lzss_pkg::PH_HEADER: begin
                        if (r_hcnt == 2'd3) begin
                            n_rem   = (hdr_acc > SIZE_MAX) ? SIZE_MAX : hdr_acc;
                            n_hcnt  = 2'd0;
                            n_phase = (n_rem == '0) ? lzss_pkg::PH_IDLE : lzss_pkg::PH_FLAG;
                        end else begin
                            n_rem  = hdr_acc;
                            n_hcnt = r_hcnt + 1'b1;
                        end
                    end
                    lzss_pkg::PH_FLAG: begin
                        n_flags = i_in_byte;
                        n_fused = '0;
                        n_phase = lzss_pkg::PH_TOKEN;
                    end
                    lzss_pkg::PH_TOKEN: begin
                        if (r_flags[7]) begin
                            n_tok_hi = i_in_byte;
                            n_phase  = lzss_pkg::PH_REF_LO;
                        end else begin
                            lit_push = 1'b1;
                            lit_end  = (rem_dec == '0);
                            n_rem    = rem_dec;
                            n_flags  = {r_flags[6:0], 1'b0};
                            n_fused  = fused_inc;
                            n_phase  = (rem_dec == '0) ? lzss_pkg::PH_IDLE :
                                       (fused_inc >= lzss_pkg::FLAG_COUNT) ?
                                       lzss_pkg::PH_FLAG : lzss_pkg::PH_TOKEN;
                        end
                    end
                    lzss_pkg::PH_REF_LO: begin
                        ref_start = 1'b1;
                        ref_end   = (rem_ref == '0);
                        n_rem     = rem_ref;
                        n_flags   = {r_flags[6:0], 1'b0};
                        n_fused   = fused_inc;
                        n_phase   = (rem_ref == '0) ? lzss_pkg::PH_IDLE :
                                    (fused_inc >= lzss_pkg::FLAG_COUNT) ?
                                    lzss_pkg::PH_FLAG : lzss_pkg::PH_TOKEN;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    assign issue = lit_push || cp_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lzss_pkg::PH_IDLE;
            r_hcnt    <= '0;
            r_rem     <= '0;
            r_flags   <= '0;
            r_fused   <= '0;
            r_tok_hi  <= '0;
            r_iptr    <= '0;
            r_prod    <= '0;
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_ref_end <= 1'b0;
            r_s2_vld  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_rem    <= n_rem;
            r_flags  <= n_flags;
            r_fused  <= n_fused;
            r_tok_hi <= n_tok_hi;

            if (issue) begin
                r_iptr <= r_iptr + 1'b1;
            end
            if (first_acc) begin
                r_prod <= '0;
            end else if (issue && r_prod != PROD_MAX) begin
                r_prod <= r_prod + 1'b1;
            end

            if (ref_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= ref_len;
                r_ref_end <= ref_end;
            end else if (cp_issue) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                end
            end

            if (issue) begin
                r_s2_vld <= 1'b1;
            end else if (pop) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    // Output stage payload, loaded with each issued byte; also the copy distance and last output byte.
    always_ff @(posedge i_clk) begin
        if (ref_start) begin
            r_disp <= ref_disp;
        end
        if (issue) begin
            r_s2_src  <= lit_push ? lzss_pkg::SRC_LIT : cp_src;
            r_s2_lit  <= i_in_byte;
            r_s2_addr <= r_iptr;
            r_s2_last <= lit_push || (r_cnt == 5'd1);
            r_s2_end  <= lit_push ? lit_end : (r_cnt == 5'd1 && r_ref_end);
        end
        if (pop) begin
            r_last_byte <= o_out_byte;
        end
    end

    // History window. A distance of one never reads it: the byte being written is the
    // one wanted, so it comes from the last-byte register instead.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            mem[r_s2_addr] <= o_out_byte;
        end
        if (cp_issue && cp_src == lzss_pkg::SRC_MEM) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_comb begin
        case (r_s2_src)
            lzss_pkg::SRC_MEM:  o_out_byte = r_mem_q;
            lzss_pkg::SRC_LAST: o_out_byte = r_last_byte;
            lzss_pkg::SRC_LIT:  o_out_byte = r_s2_lit;
            default:            o_out_byte = 8'd0;
        endcase
    end

    assign o_out_valid  = r_s2_vld;
    assign o_run_last   = r_s2_last;
    assign o_stream_end = r_s2_end;

endmodule

/* tb/lzss_stream_decompressor_test.sv */
module lzss_stream_decompressor_test;

    localparam int WINDOW        = 4096;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 40;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_input;
        logic       ends_stream;
    } t_out_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_first_of_stream;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_stream_end;

    // Decoder state as seen from the outside.
    logic [7:0]  hist [WINDOW];
    logic [11:0] wr_ptr;
    logic [12:0] stream_count;
    logic [23:0] left_to_emit;
    logic [2:0]  phase;
    logic [1:0]  hdr_idx;
    logic [7:0]  flags;
    logic [3:0]  flags_taken;
    logic [7:0]  ref_hi;

    t_out_beat expected_bytes[$];

    bit steady;
    int hold_left;
    int idle_cycles = 0;
    int failures;
    int bytes_sent;
    int streams_opened;
    int bytes_checked;

    lzss_stream_decompressor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_first_of_stream (i_first_of_stream),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_run_last        (o_run_last),
        .o_stream_end      (o_stream_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic store_byte(input logic [7:0] value);
        hist[wr_ptr] = value;
        wr_ptr++;
        if (stream_count < WINDOW) begin
            stream_count++;
        end
    endtask

    task automatic end_token();
        flags = flags << 1;
        flags_taken++;
        if (left_to_emit == 0) begin
            phase = lzss_pkg::PH_IDLE;
        end else if (flags_taken >= lzss_pkg::FLAG_COUNT) begin
            phase = lzss_pkg::PH_FLAG;
        end else begin
            phase = lzss_pkg::PH_TOKEN;
        end
    endtask

    // Works out the output bytes that one accepted input byte gives.
    task automatic decode_byte(input logic [7:0] b, input logic first);
        int          idx;
        int          len;
        int          i;
        logic [12:0] back;
        logic [7:0]  value;
        if (first) begin
            stream_count = '0;
            left_to_emit = '0;
            hdr_idx      = 2'd1;
            flags        = '0;
            flags_taken  = '0;
            ref_hi       = '0;
            phase        = lzss_pkg::PH_HEADER;
        end else begin
            case (phase)
                lzss_pkg::PH_HEADER: begin
                    idx = int'(hdr_idx);
                    left_to_emit[8 * (idx - 1) +: 8] = b;
                    if (hdr_idx == 2'd3) begin
                        hdr_idx = '0;
                        phase   = (left_to_emit == 0) ? lzss_pkg::PH_IDLE : lzss_pkg::PH_FLAG;
                    end else begin
                        hdr_idx++;
                    end
                end
                lzss_pkg::PH_FLAG: begin
                    flags       = b;
                    flags_taken = '0;
                    phase       = lzss_pkg::PH_TOKEN;
                end
                lzss_pkg::PH_TOKEN: begin
                    if (flags[7]) begin
                        ref_hi = b;
                        phase  = lzss_pkg::PH_REF_LO;
                    end else begin
                        store_byte(b);
                        left_to_emit--;
                        expected_bytes.push_back({b, 1'b1, left_to_emit == 0});
                        end_token();
                    end
                end
                lzss_pkg::PH_REF_LO: begin
                    len  = int'(ref_hi[7:4]) + int'(lzss_pkg::MIN_MATCH);
                    back = {1'b0, ref_hi[3:0], b} + 13'd1;
                    if (len > left_to_emit) begin
                        len = int'(left_to_emit);
                    end
                    for (i = 0; i < len; i++) begin
                        // Bytes from before the start of this stream read as zero.
                        value = (back <= stream_count) ? hist[wr_ptr - back[11:0]] : 8'h00;
                        store_byte(value);
                        expected_bytes.push_back({value, i == len - 1,
                                                  (i == len - 1) && (left_to_emit == len)});
                    end
                    left_to_emit = left_to_emit - 24'(len);
                    end_token();
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic first);
        int gap;
        gap = (!steady && $urandom_range(99) < 17) ? $urandom_range(1, 2) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_in_byte         = value;
        i_first_of_stream = first;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        bytes_sent++;
        if (first) begin
            streams_opened++;
        end
        decode_byte(value, first);
    endtask

    // Sends a well-formed stream of the given size; a cut of zero or more abandons
    // it after that many tokens.
    task automatic send_stream(input logic [23:0] size, input int cut);
        logic [7:0]  flag;
        logic [11:0] d;
        int          made;
        int          tokens;
        int          len;
        int          offset;
        int          bit_i;
        made   = 0;
        tokens = 0;
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(size[7:0], 1'b0);
        send_byte(size[15:8], 1'b0);
        send_byte(size[23:16], 1'b0);
        while (made < size && tokens != cut) begin
            flag = 8'($urandom_range(255));
            send_byte(flag, 1'b0);
            for (bit_i = 7; bit_i >= 0 && made < size && tokens != cut; bit_i--) begin
                if (flag[bit_i]) begin
                    len = $urandom_range(3, 18);
                    if (made == 0 || $urandom_range(9) == 0) begin
                        offset = $urandom_range(1, WINDOW);
                    end else begin
                        offset = $urandom_range(1, (made < 64) ? made : 64);
                    end
                    d = 12'(offset - 1);
                    send_byte({4'(len - 3), d[11:8]}, 1'b0);
                    send_byte(d[7:0], 1'b0);
                    made += len;
                end else begin
                    send_byte(8'($urandom_range(255)), 1'b0);
                    made++;
                end
                tokens++;
            end
        end
    endtask

    task automatic test_reset();
        i_rst_n = 1'b0;
        foreach (hist[k]) begin
            hist[k] = '0;
        end
        wr_ptr       = '0;
        stream_count = '0;
        left_to_emit = '0;
        phase        = lzss_pkg::PH_IDLE;
        hdr_idx      = '0;
        flags        = '0;
        flags_taken  = '0;
        ref_hi       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // A literal followed by a long run at distance one that is cut short by the size.
    task automatic test_literal_and_clipped_copy();
        send_byte(8'h10, 1'b1);
        send_byte(8'h09, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_idle_bytes_ignored();
        send_byte(8'h5A, 1'b0);
    endtask

    // The largest distance on a fresh stream points before its start.
    task automatic test_copy_before_start();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // A stream of the largest size is abandoned by a new header that declares no output.
    task automatic test_restart_and_zero_size();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        send_stream(24'd60, -1);
    endtask

    task automatic test_full_rate();
        steady = 1'b1;
        send_stream(24'd40, -1);
        steady = 1'b0;
    endtask

    task automatic test_random_streams();
        int start;
        int noise;
        int size;
        int cut;
        start = bytes_sent;
        noise = 0;
        while (bytes_sent - start - noise < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       size = 0;
                1:       size = $urandom_range(49, 300);
                default: size = $urandom_range(1, 48);
            endcase
            cut = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : -1;
            send_stream(24'(size), cut);
            // Stray bytes: ignored when the stream has ended, parsed when it was cut.
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom_range(255)), 1'b0);
                    noise++;
                end
            end
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = steady || ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge i_clk) begin : check_output
        t_out_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                $error("output byte %02h arrived with nothing expected", o_out_byte);
                failures++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    failures++;
                end
                if (o_run_last !== want.last_of_input) begin
                    $error("run_last: expected %0b, got %0b", want.last_of_input, o_run_last);
                    failures++;
                end
                if (o_stream_end !== want.ends_stream) begin
                    $error("stream_end: expected %0b, got %0b", want.ends_stream, o_stream_end);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Timed out with %0d output bytes outstanding.", expected_bytes.size());
        $display("lzss_stream_decompressor verification failed");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_in_byte         = '0;
        i_first_of_stream = 1'b0;
        steady            = 1'b0;
        hold_left         = 0;
        failures          = 0;
        bytes_sent        = 0;
        streams_opened    = 0;
        bytes_checked     = 0;
        test_reset();
        test_literal_and_clipped_copy();
        test_idle_bytes_ignored();
        test_copy_before_start();
        test_restart_and_zero_size();
        test_backpressure();
        test_full_rate();
        test_random_streams();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_bytes.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Decoded %0d compressed bytes over %0d streams into %0d checked output bytes,",
                 bytes_sent, streams_opened, bytes_checked);
        $display("with literals, clipped and out-of-range copies, restarts and a long output stall.");
        if (failures == 0) begin
            $display("lzss_stream_decompressor verification clean");
        end else begin
            $display("lzss_stream_decompressor verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lzss_pkg.sv
hdl/lzss_stream_decompressor.sv
tb/lzss_stream_decompressor_test.sv
